// ===== hdl/fir_pkg.sv =====
// Shared types and constants for the FIR filter block.
// Command/status structs between controller and datapath, register indexes.
// No dependencies.
package fir_pkg;

    localparam int COEF_W      = 16;   // Q1.15 coefficient width
    localparam int COEF_LANES  = 4;    // coefficients per configuration word
    localparam int CFG_DATA_W  = 64;   // widest configuration register
    localparam int CFG_IDX_W   = 3;    // register index width
    localparam int TAP_CNT_W   = 5;    // tap_count register width
    localparam int FRAC_SHIFT  = 15;   // Q4.27 -> Q3.12
    localparam int GUARD_BITS  = 4;    // headroom for up to 16 terms

    localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_A    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_B    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_C    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_D    = 3'd4;

    localparam logic [TAP_CNT_W-1:0] TAP_COUNT_RESET = 5'd1;

    // controller -> datapath
    typedef struct packed {
        logic start;     // input beat accepted: shift history, update count
        logic mac_step;  // multiply tap at current index, advance index
        logic acc_en;    // add the registered product into the accumulator
        logic load_out;  // load output register from accumulator
    } fir_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic warming;   // current item lacks history
        logic mac_last;  // current index is the last tap in use
        logic out_free;  // output register can take a new result
    } fir_status_t;

endpackage

// ===== hdl/fir_ctrl.sv =====
// FIR filter sequencer: accept, setup, multiply-accumulate walk, drain, emit.
// Depends on fir_pkg for the command and status structs.
module fir_ctrl
    import fir_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  fir_status_t status,
    output fir_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_MAC,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   acc_en_reg, acc_en_next;

    always_comb begin
        state_next  = state_reg;
        acc_en_next = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                state_next = status.warming ? ST_EMIT : ST_MAC;
            end
            ST_MAC: begin
                acc_en_next = 1'b1;
                if (status.mac_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            acc_en_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            acc_en_reg <= acc_en_next;
        end
    end

    assign in_ready     = (state_reg == ST_IDLE);
    assign cmd.start    = in_ready && in_valid;
    assign cmd.mac_step = (state_reg == ST_MAC);
    assign cmd.acc_en   = acc_en_reg;   // high in the cycle after each product register load
    assign cmd.load_out = (state_reg == ST_EMIT) && status.out_free;

endmodule

// ===== hdl/fir_datapath.sv =====
// FIR filter datapath: config registers, history line, MAC, round/saturate, output register.
// Depends on fir_pkg; driven by fir_ctrl commands.
module fir_datapath
    import fir_pkg::*;
#(
    parameter int MAX_TAPS    = 16,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic                          first,
    input  fir_cmd_t                      cmd,
    output fir_status_t                   status,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic signed [SAMPLE_BITS-1:0] filtered,
    output logic                          warming,
    output logic                          clipped
);

    localparam int IDX_W  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int CNT_W  = $clog2(MAX_TAPS + 1);
    localparam int PROD_W = COEF_W + SAMPLE_BITS;
    localparam int ACC_W  = PROD_W + GUARD_BITS;
    localparam int COEF_ALL_W = 4 * CFG_DATA_W;

    localparam logic [TAP_CNT_W-1:0] MAX_TAPS_C = TAP_CNT_W'(MAX_TAPS);
    localparam logic [CNT_W-1:0]     SEEN_MAX   = CNT_W'(MAX_TAPS);
    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (FRAC_SHIFT - 1);
    localparam logic signed [ACC_W-1:0] SAT_HI =
        {{(ACC_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

    // configuration
    logic [TAP_CNT_W-1:0]  tap_count_reg;
    logic [CFG_DATA_W-1:0] coef_a_reg, coef_b_reg, coef_c_reg, coef_d_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tap_count_reg <= TAP_COUNT_RESET;
            coef_a_reg    <= '0;
            coef_b_reg    <= '0;
            coef_c_reg    <= '0;
            coef_d_reg    <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_TAP_COUNT: tap_count_reg <= cfg_data[TAP_CNT_W-1:0];
                REG_COEF_A:    coef_a_reg    <= cfg_data;
                REG_COEF_B:    coef_b_reg    <= cfg_data;
                REG_COEF_C:    coef_c_reg    <= cfg_data;
                REG_COEF_D:    coef_d_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // tap count clamped to 1..MAX_TAPS
    logic [TAP_CNT_W-1:0] taps_eff;
    always_comb begin
        if (tap_count_reg == '0) begin
            taps_eff = TAP_CNT_W'(1);
        end else if (tap_count_reg > MAX_TAPS_C) begin
            taps_eff = MAX_TAPS_C;
        end else begin
            taps_eff = tap_count_reg;
        end
    end

    // block sample count, saturating
    logic [CNT_W-1:0] seen_reg, seen_base, seen_next;
    always_comb begin
        seen_base = first ? '0 : seen_reg;
        seen_next = (seen_base < SEEN_MAX) ? seen_base + CNT_W'(1) : seen_base;
    end

    logic             warming_reg;
    logic [IDX_W-1:0] taps_m1_reg;
    logic [IDX_W-1:0] idx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg <= '0;
        end else if (cmd.start) begin
            seen_reg <= seen_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            warming_reg <= (TAP_CNT_W'(seen_next) < taps_eff);
            taps_m1_reg <= IDX_W'(taps_eff - TAP_CNT_W'(1));
            idx_reg     <= '0;
        end else if (cmd.mac_step) begin
            idx_reg     <= idx_reg + IDX_W'(1);
        end
    end

    // history line, newest in entry 0; no reset, reads stay within the block
    logic signed [SAMPLE_BITS-1:0] hist_reg [MAX_TAPS];
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            hist_reg[0] <= sample;
            for (int i = 1; i < MAX_TAPS; i++) begin
                hist_reg[i] <= hist_reg[i-1];
            end
        end
    end

    // multiply, registered, then accumulate
    logic [COEF_ALL_W-1:0]     coef_all;
    logic signed [COEF_W-1:0]  coef_sel;
    logic signed [PROD_W-1:0]  prod_next, prod_reg;
    logic signed [ACC_W-1:0]   acc_reg;

    assign coef_all  = {coef_d_reg, coef_c_reg, coef_b_reg, coef_a_reg};
    assign coef_sel  = $signed(coef_all[COEF_W*idx_reg +: COEF_W]);
    assign prod_next = coef_sel * hist_reg[idx_reg];

    always_ff @(posedge aclk) begin
        if (cmd.mac_step) begin
            prod_reg <= prod_next;
        end
        if (cmd.start) begin
            acc_reg <= '0;
        end else if (cmd.acc_en) begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    // round half up and saturate
    logic signed [ACC_W-1:0] rnd;
    logic signed [ACC_W-1:0] sum_rnd;
    logic signed [SAMPLE_BITS-1:0] sat_val;
    logic sat_hit;

    always_comb begin
        sum_rnd = acc_reg + ROUND_HALF;
        rnd     = sum_rnd >>> FRAC_SHIFT;
        sat_hit = 1'b1;
        if (rnd > SAT_HI) begin
            sat_val = SAT_HI[SAMPLE_BITS-1:0];
        end else if (rnd < SAT_LO) begin
            sat_val = SAT_LO[SAMPLE_BITS-1:0];
        end else begin
            sat_val = rnd[SAMPLE_BITS-1:0];
            sat_hit = 1'b0;
        end
    end

    // output register
    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] filtered_reg;
    logic                          warm_out_reg, clip_out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            filtered_reg <= warming_reg ? '0 : sat_val;
            warm_out_reg <= warming_reg;
            clip_out_reg <= !warming_reg && sat_hit;
        end
    end

    assign status.warming  = warming_reg;
    assign status.mac_last = (idx_reg == taps_m1_reg);
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign filtered  = filtered_reg;
    assign warming   = warm_out_reg;
    assign clipped   = clip_out_reg;

endmodule

// ===== hdl/fir_filter_top.sv =====
// FIR filter top level: stream ports, configuration port, controller and datapath.
// Depends on fir_pkg, fir_ctrl and fir_datapath.
//
// Usage:
//   Input stream (s_*): one sample per beat in s_tdata, s_tuser marks the first
//   sample of a new block. Output stream (m_*): one result beat per input beat.
//   Configuration: cfg_wr_en writes cfg_data into register cfg_index on a clock
//   edge (0 tap_count, 1..4 coefficient words). Write only while idle.
// Timing:
//   One shared multiplier walks the taps, one per cycle, behind a product
//   register. An item goes through accept, setup, one MAC step per tap in
//   use, drain and emit; a warming item goes from setup straight to emit.
//   The next beat is taken after the output register loads.
// Reset (aresetn low, synchronous): tap_count=1, coefficients zero, block
//   count zero, output empty. History is not cleared; warm-up covers it.
// Stall: a result holds in the output register while m_tready is low; the
//   next item is accepted and computed meanwhile but waits in the emit step
//   until the output register is free.
module fir_filter_top
    import fir_pkg::*;
#(
    parameter int MAX_TAPS    = 16,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_tdata, // [SAMPLE_BITS-1:0] sample
    input  logic                  s_tuser,   // [0] first
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] m_tdata, // [SAMPLE_BITS-1:0] filtered
    output logic [1:0]            m_tuser    // [0] warming, [1] clipped
);

    localparam int DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

    fir_cmd_t    cmd;
    fir_status_t status;

    logic signed [SAMPLE_BITS-1:0] filtered;
    logic                          warming;
    logic                          clipped;

    fir_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    fir_datapath #(
        .MAX_TAPS    (MAX_TAPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    ($signed(s_tdata[SAMPLE_BITS-1:0])),
        .first     (s_tuser),
        .cmd       (cmd),
        .status    (status),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .filtered  (filtered),
        .warming   (warming),
        .clipped   (clipped)
    );

    // zero-pad the sample to whole bytes
    assign m_tdata = DATA_W'($unsigned(filtered));
    assign m_tuser = {clipped, warming};

    // one item at a time: no second beat right after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input beat accepted while busy");

    // a warming result carries zero data and no clip flag
    a_warm_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == '0 && !m_tuser[1]))
        else $error("warming result not zero");

    // a new result is only loaded from the emit step, never while idle
    a_emit_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without work in progress");

endmodule

// ===== verif/testbench.sv =====
// Self-checking bench for fir_filter_top: directed and random sample streams,
// with a tracking model of the filter that predicts every output beat.
// Depends on fir_pkg and the fir_filter_top RTL.
module testbench;
    import fir_pkg::*;

    localparam int DATA_W         = 16;
    localparam int TAP_LIMIT      = 16;
    localparam int SAMPLE_HI      = 32767;
    localparam int SAMPLE_LO      = -32768;
    localparam int RESET_CYCLES   = 9;
    localparam int SETTLE_CYCLES  = 40;    // longer than a full 16-tap item takes
    localparam int HOLD_CYCLES    = 400;   // long sink stall
    localparam int HOLD_AT_ITEM   = 500;
    localparam int STEADY_FROM    = 1100;  // sender inserts no random gaps in this item range
    localparam int STEADY_TO      = 1400;
    localparam int RX_STEADY_FROM = 12000; // sink never idles in this cycle range
    localparam int RX_STEADY_TO   = 16000;
    localparam int RAND_PHASES    = 8;
    localparam int PHASE_ITEMS    = 250;
    localparam int WATCHDOG_LIMIT = 5000;

    localparam logic [CFG_IDX_W-1:0] COEF_REGS [4] =
        '{REG_COEF_A, REG_COEF_B, REG_COEF_C, REG_COEF_D};
    localparam logic [15:0] EXTREMES [5] =
        '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001};

    typedef struct packed {
        logic [15:0] filtered;
        logic        warming;
        logic        clipped;
    } fir_result_t;

    // Tracks register contents, sample history and block length; predicts
    // one output beat per accepted input beat.
    class fir_tracker;
        logic [TAP_CNT_W-1:0]  tap_reg;
        logic [CFG_DATA_W-1:0] coef_words [4];
        logic signed [15:0]    delay_line [TAP_LIMIT];
        int                    block_len;
        fir_result_t           pending_results [$];
        int                    mismatches;

        function new();
            tap_reg = TAP_COUNT_RESET;
            foreach (coef_words[i]) coef_words[i] = '0;
            foreach (delay_line[i]) delay_line[i] = '0;
            block_len  = 0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_TAP_COUNT: tap_reg = data[TAP_CNT_W-1:0];
                REG_COEF_A:    coef_words[0] = data;
                REG_COEF_B:    coef_words[1] = data;
                REG_COEF_C:    coef_words[2] = data;
                REG_COEF_D:    coef_words[3] = data;
                default: ;     // out-of-range index is dropped
            endcase
        endfunction

        function void note_sample(logic signed [15:0] smp, logic first);
            int          n;
            longint      acc;
            longint      r;
            logic [15:0] c;
            fir_result_t res;
            n = int'(tap_reg);
            if (n == 0) n = 1;
            if (n > TAP_LIMIT) n = TAP_LIMIT;
            if (first) block_len = 0;
            for (int i = TAP_LIMIT - 1; i > 0; i--) delay_line[i] = delay_line[i-1];
            delay_line[0] = smp;
            if (block_len < TAP_LIMIT) block_len++;
            res = '0;
            if (block_len < n) begin
                res.warming = 1'b1;
            end else begin
                acc = 0;
                for (int i = 0; i < n; i++) begin
                    c = coef_words[i/4][(i%4)*16 +: 16];
                    acc += longint'($signed(c)) * longint'(delay_line[i]);
                end
                // Q4.27 -> Q3.12, round half up, then saturate
                r = (acc + 16384) >>> 15;
                if (r > SAMPLE_HI) begin
                    r = SAMPLE_HI;
                    res.clipped = 1'b1;
                end else if (r < SAMPLE_LO) begin
                    r = SAMPLE_LO;
                    res.clipped = 1'b1;
                end
                res.filtered = r[15:0];
            end
            pending_results.push_back(res);
        endfunction

        function void check_result(logic [15:0] filt, logic warm, logic clip);
            fir_result_t exp_res;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected beat: filtered %h warming %b clipped %b",
                         $time, filt, warm, clip);
                mismatches++;
                return;
            end
            exp_res = pending_results.pop_front();
            if (filt !== exp_res.filtered) begin
                $display("%0t: filtered expected %h actual %h", $time, exp_res.filtered, filt);
                mismatches++;
            end
            if (warm !== exp_res.warming) begin
                $display("%0t: warming expected %b actual %b", $time, exp_res.warming, warm);
                mismatches++;
            end
            if (clip !== exp_res.clipped) begin
                $display("%0t: clipped expected %b actual %b", $time, exp_res.clipped, clip);
                mismatches++;
            end
        endfunction
    endclass

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [DATA_W-1:0]     s_tdata   = '0;   // [15:0] sample
    logic                  s_tuser   = 1'b0; // [0] first
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [DATA_W-1:0]     m_tdata;          // [15:0] filtered
    logic [1:0]            m_tuser;          // [0] warming, [1] clipped

    fir_tracker  sb = new();
    logic [15:0] coef_set [TAP_LIMIT];
    int          items_sent  = 0;
    int          idle_cycles = 0;
    bit          hold_cue    = 1'b0;

    fir_filter_top #(
        .MAX_TAPS    (TAP_LIMIT),
        .SAMPLE_BITS (16)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Beat monitor and watchdog; values seen here are the pre-edge ones.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                sb.note_sample(s_tdata[15:0], s_tuser);
            end
            if (m_tvalid && m_tready) begin
                sb.check_result(m_tdata[15:0], m_tuser[0], m_tuser[1]);
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // Result sink: random back-pressure, one steady window, one long hold.
    initial begin : result_sink
        int rx_cycle;
        int hold_left;
        bit hold_done;
        rx_cycle  = 0;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge aclk);
            rx_cycle++;
            if (hold_cue && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (rx_cycle >= RX_STEADY_FROM && rx_cycle < RX_STEADY_TO) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(99) >= 14);
            end
        end
    end

    task automatic send_sample(input logic [15:0] smp, input logic first, input bit steady);
        int gap;
        gap = 0;
        if (!steady && $urandom_range(99) < 14) gap = $urandom_range(1, 20);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tuser  <= first;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        if (items_sent == HOLD_AT_ITEM) hold_cue = 1'b1;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        sb.write_reg(idx, data);
    endtask

    // Drain all results, let the pipeline go quiet, then load a new setting.
    task automatic apply_setting(input logic [TAP_CNT_W-1:0] taps, input bit junk_write);
        logic [CFG_DATA_W-1:0] word;
        while (sb.pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        write_reg(REG_TAP_COUNT, CFG_DATA_W'(taps));
        for (int w = 0; w < 4; w++) begin
            for (int l = 0; l < 4; l++) word[l*16 +: 16] = coef_set[w*4 + l];
            write_reg(COEF_REGS[w], word);
        end
        if (junk_write)
            write_reg(CFG_IDX_W'($urandom_range(REG_COEF_D + 1, (1 << CFG_IDX_W) - 1)),
                      {$urandom, $urandom});
        cfg_wr_en <= 1'b0;
    endtask

    task automatic pick_coefs(input logic [TAP_CNT_W-1:0] taps);
        int n;
        int mode;
        logic [15:0] lp;
        n = int'(taps);
        if (n == 0) n = 1;
        if (n > TAP_LIMIT) n = TAP_LIMIT;
        mode = $urandom_range(3);
        lp = (n == 1) ? 16'h7FFF : 16'((32768 + n / 2) / n);
        for (int i = 0; i < TAP_LIMIT; i++) begin
            case (mode)
                0: coef_set[i] = 16'($urandom);
                1: coef_set[i] = (i < n) ? lp : 16'($urandom);   // moving average
                2: coef_set[i] = (i == 0) ? 16'((32768 * (n - 1) + n / 2) / n)
                                          : 16'(-((32768 + n / 2) / n)); // high-pass
                default: coef_set[i] = EXTREMES[$urandom_range(4)];
            endcase
        end
    endtask

    // Mostly whole blocks led by a first flag; some blocks carry random flags.
    task automatic stream_blocks(input int n_items);
        int          run_left;
        int          style;
        bit          noise;
        logic        first;
        logic [15:0] smp;
        run_left = $urandom_range(1) ? $urandom_range(1, 20) : 0; // maybe carry on
        style    = $urandom_range(2);
        noise    = 1'b0;
        for (int k = 0; k < n_items; k++) begin
            if (run_left == 0) begin
                run_left = $urandom_range(1, 48);
                style    = $urandom_range(2);
                noise    = ($urandom_range(9) == 0);
                first    = 1'b1;
            end else begin
                first = noise ? 1'($urandom_range(1)) : 1'b0;
            end
            case (style)
                0: smp = 16'($urandom);
                1: smp = 16'($urandom_range(2047)) - 16'd1024;
                default: smp = EXTREMES[$urandom_range(4)];
            endcase
            send_sample(smp, first,
                        items_sent >= STEADY_FROM && items_sent < STEADY_TO);
            run_left--;
        end
        s_tvalid <= 1'b0;
    endtask

    initial begin : stimulus
        logic [TAP_CNT_W-1:0] taps;
        int r;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings, no first flag yet: block counts from reset
        send_sample(16'h1234, 1'b0, 1'b0);
        send_sample(16'hFEDC, 1'b0, 1'b0);
        s_tvalid <= 1'b0;

        // four taps near full scale: positive and negative saturation
        for (int i = 0; i < TAP_LIMIT; i++) coef_set[i] = 16'($urandom);
        coef_set[0] = 16'h7FFF;
        coef_set[1] = 16'h7FFF;
        coef_set[2] = 16'h7FFF;
        coef_set[3] = 16'h8000;
        apply_setting(5'd4, 1'b1);
        send_sample(16'h7FFF, 1'b1, 1'b0);
        repeat (3) send_sample(16'h7FFF, 1'b0, 1'b0);
        repeat (3) send_sample(16'h8000, 1'b0, 1'b0);
        send_sample(16'h8000, 1'b1, 1'b0);
        repeat (3) send_sample(16'h8000, 1'b0, 1'b0);
        send_sample(16'h0000, 1'b1, 1'b0);
        send_sample(16'hFFFF, 1'b0, 1'b0);
        send_sample(16'h0001, 1'b0, 1'b0);
        send_sample(16'h7FFF, 1'b0, 1'b0);
        s_tvalid <= 1'b0;

        // zero tap count behaves as one tap; coefficient -1 clips -(-1)
        coef_set[0] = 16'h8000;
        apply_setting(5'd0, 1'b0);
        send_sample(16'h8000, 1'b1, 1'b0);
        send_sample(16'h7FFF, 1'b0, 1'b0);
        send_sample(16'h0000, 1'b0, 1'b0);
        send_sample(16'hFFFF, 1'b1, 1'b0);
        s_tvalid <= 1'b0;

        // oversized tap count acts as 16; block continues, so it warms again
        for (int i = 0; i < TAP_LIMIT; i++) coef_set[i] = 16'($urandom);
        apply_setting(5'd31, 1'b0);
        repeat (6) send_sample(16'($urandom), 1'b0, 1'b0);
        s_tvalid <= 1'b0;

        for (int p = 0; p < RAND_PHASES; p++) begin
            r = $urandom_range(99);
            if (r < 50)      taps = TAP_CNT_W'($urandom_range(1, 8));
            else if (r < 70) taps = TAP_CNT_W'($urandom_range(9, 15));
            else if (r < 85) taps = TAP_CNT_W'(TAP_LIMIT);
            else if (r < 92) taps = '0;
            else             taps = TAP_CNT_W'($urandom_range(TAP_LIMIT + 1, 31));
            pick_coefs(taps);
            apply_setting(taps, $urandom_range(3) == 0);
            stream_blocks(PHASE_ITEMS);
        end

        while (sb.pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== fir_filter_top.f =====
hdl/fir_pkg.sv
hdl/fir_ctrl.sv
hdl/fir_datapath.sv
hdl/fir_filter_top.sv
verif/testbench.sv
